[hw/rtl/esc_pkg.sv]
// Shared types and constants for the raw sensor compensation pipeline.
package esc_pkg;

    typedef enum logic [2:0] {
        CFG_TEMP     = 3'd0,
        CFG_PRESS_LO = 3'd1,
        CFG_PRESS_HI = 3'd2,
        CFG_PRESS_P9 = 3'd3,
        CFG_HUM      = 3'd4
    } t_cfg_idx;

    localparam logic signed [32:0] PRESS_T_OFS   = 33'sd128000;
    localparam logic signed [63:0] PRESS_P1_BIAS = 64'sh0000_8000_0000_0000;
    localparam logic [20:0]        PRESS_ADC_OFS = 21'd1048576;
    localparam logic [63:0]        PRESS_SCALE   = 64'd3125;
    localparam logic signed [31:0] HUM_T_OFS     = 32'sd76800;
    localparam logic [31:0]        HUM_ROUND     = 32'd16384;
    localparam logic signed [31:0] HUM_Y_OFS     = 32'sd32768;
    localparam logic signed [31:0] HUM_Y_BIAS    = 32'sd2097152;
    localparam logic signed [31:0] HUM_Y_ROUND   = 32'sd8192;
    localparam logic signed [31:0] HUM_CLAMP     = 32'sd419430400;
    localparam logic [16:0]        HUM_MAX_Q10   = 17'd102400;
    localparam logic signed [31:0] TEMP_ROUND    = 32'sd128;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_invalid;
    } t_out;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } t_cal;

    typedef struct packed {
        logic [19:0]        adc_p;
        logic [15:0]        adc_h;
        logic signed [31:0] tfine;
        logic signed [31:0] temp;
    } t_tstage;

    typedef struct packed {
        logic [19:0]        adc_p;
        logic signed [31:0] tfine;
        logic signed [31:0] temp;
        logic [16:0]        hum;
    } t_hstage;

    typedef struct packed {
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [31:0] temp;
        logic [16:0]        hum;
    } t_pstage;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [16:0]        hum;
        logic               inval;
        logic               neg;
    } t_div_side;

    typedef struct packed {
        logic signed [63:0] quot;
        logic signed [31:0] temp;
        logic [16:0]        hum;
        logic               inval;
    } t_qstage;

endpackage

[hw/rtl/esc_if.sv]
// Request and result stream interfaces of the compensation block.
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;

    modport source (output valid, output raw_pressure, output raw_temperature,
                    output raw_humidity, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature,
                    input raw_humidity, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output humidity_q22_10, output pressure_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input humidity_q22_10, input pressure_invalid, output ready);
endinterface

[hw/rtl/esc_temp.sv]
// Three-stage temperature compensation producing the fine-temperature term.
module esc_temp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  esc_pkg::t_in     i_data,
    input  esc_pkg::t_cal    i_cal,
    output logic             o_valid,
    output esc_pkg::t_tstage o_data
);
    import esc_pkg::*;

    logic [2:0]         r_v;
    logic signed [17:0] a;
    logic signed [16:0] b;
    logic signed [33:0] a_t2;
    logic signed [33:0] b_sq;
    logic signed [31:0] bsq_sh;
    logic signed [35:0] m3;
    logic signed [31:0] tv2;
    logic signed [31:0] tfine;
    logic signed [31:0] temp;
    logic signed [31:0] r_at2;
    logic signed [31:0] r_bsq;
    logic signed [31:0] r_tv1;
    logic signed [31:0] r_m3;
    t_in                r_in1;
    t_in                r_in2;
    t_tstage            r_out;

    always_comb begin
        a      = $signed({1'b0, i_data.raw_temperature[19:3]})
               - $signed({1'b0, i_cal.t1, 1'b0});
        b      = $signed({1'b0, i_data.raw_temperature[19:4]}) - $signed({1'b0, i_cal.t1});
        a_t2   = a * i_cal.t2;
        b_sq   = b * b;
        bsq_sh = r_bsq >>> 12;
        m3     = $signed(bsq_sh[19:0]) * i_cal.t3;
        tv2    = r_m3 >>> 14;
        tfine  = r_tv1 + tv2;
        temp   = ((tfine <<< 2) + tfine + TEMP_ROUND) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_at2       <= a_t2[31:0];
            r_bsq       <= b_sq[31:0];
            r_in1       <= i_data;
            r_tv1       <= r_at2 >>> 11;
            r_m3        <= m3[31:0];
            r_in2       <= r_in1;
            r_out.adc_p <= r_in2.raw_pressure;
            r_out.adc_h <= r_in2.raw_humidity;
            r_out.tfine <= tfine;
            r_out.temp  <= temp;
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r_out;

endmodule

[hw/rtl/esc_hum.sv]
// Six-stage humidity compensation with clamp to the full-scale range.
module esc_hum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  esc_pkg::t_tstage i_data,
    input  esc_pkg::t_cal    i_cal,
    output logic             o_valid,
    output esc_pkg::t_hstage o_data
);
    import esc_pkg::*;

    logic [5:0]         r_v;
    logic signed [31:0] v;
    logic signed [43:0] h5v;
    logic signed [39:0] vh6;
    logic signed [40:0] vh3;
    logic [31:0]        xpre;
    logic signed [31:0] x_full;
    logic signed [31:0] ya;
    logic signed [31:0] yb;
    logic signed [43:0] y1;
    logic signed [31:0] y2;
    logic signed [38:0] y3m;
    logic signed [31:0] y3;
    logic signed [34:0] rx;
    logic signed [31:0] s;
    logic signed [33:0] ss;
    logic signed [31:0] ss_sh;
    logic signed [33:0] th;
    logic signed [31:0] rr;
    logic signed [31:0] rc;

    logic [31:0]        r1_h5v;
    logic signed [31:0] r1_vh6;
    logic signed [31:0] r1_vh3;
    logic [31:0]        r1_xpre;
    logic signed [16:0] r2_x;
    logic signed [31:0] r2_y1;
    logic signed [16:0] r3_x;
    logic signed [31:0] r3_y3m;
    logic signed [31:0] r4_r;
    logic signed [31:0] r5_r;
    logic signed [31:0] r5_ss;
    t_tstage            r1_d;
    t_tstage            r2_d;
    t_tstage            r3_d;
    t_tstage            r4_d;
    t_tstage            r5_d;
    t_hstage            r_out;

    always_comb begin
        v      = i_data.tfine - HUM_T_OFS;
        h5v    = i_cal.h5 * v;
        vh6    = v * i_cal.h6;
        vh3    = v * $signed({1'b0, i_cal.h3});
        xpre   = {2'b00, i_data.adc_h, 14'b0} - {i_cal.h4, 20'b0} + HUM_ROUND;

        x_full = $signed(r1_xpre - r1_h5v) >>> 15;
        ya     = r1_vh6 >>> 10;
        yb     = (r1_vh3 >>> 11) + HUM_Y_OFS;
        y1     = $signed(ya[21:0]) * $signed(yb[21:0]);

        y2     = (r2_y1 >>> 10) + HUM_Y_BIAS;
        y3m    = $signed(y2[22:0]) * i_cal.h2;

        y3     = (r3_y3m + HUM_Y_ROUND) >>> 14;
        rx     = r3_x * $signed(y3[17:0]);

        s      = r4_r >>> 15;
        ss     = $signed(s[16:0]) * $signed(s[16:0]);

        ss_sh  = r5_ss >>> 7;
        th     = $signed(ss_sh[24:0]) * $signed({1'b0, i_cal.h1});
        rr     = r5_r - ($signed(th[31:0]) >>> 4);
        if (rr[31]) begin
            rc = '0;
        end else if (rr > HUM_CLAMP) begin
            rc = HUM_CLAMP;
        end else begin
            rc = rr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_h5v      <= h5v[31:0];
            r1_vh6      <= vh6[31:0];
            r1_vh3      <= vh3[31:0];
            r1_xpre     <= xpre;
            r1_d        <= i_data;
            r2_x        <= x_full[16:0];
            r2_y1       <= y1[31:0];
            r2_d        <= r1_d;
            r3_x        <= r2_x;
            r3_y3m      <= y3m[31:0];
            r3_d        <= r2_d;
            r4_r        <= rx[31:0];
            r4_d        <= r3_d;
            r5_r        <= r4_r;
            r5_ss       <= ss[31:0];
            r5_d        <= r4_d;
            r_out.adc_p <= r5_d.adc_p;
            r_out.tfine <= r5_d.tfine;
            r_out.temp  <= r5_d.temp;
            r_out.hum   <= rc[28:12];
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r_out;

endmodule

[hw/rtl/esc_press_pre.sv]
// Six-stage pressure front end forming the 64-bit dividend and divisor.
module esc_press_pre (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  esc_pkg::t_hstage i_data,
    input  esc_pkg::t_cal    i_cal,
    output logic             o_valid,
    output esc_pkg::t_pstage o_data
);
    import esc_pkg::*;

    logic [5:0]         r_v;
    logic signed [32:0] v1;
    logic signed [65:0] vv;
    logic signed [48:0] vp5;
    logic signed [48:0] vp2;
    logic signed [79:0] a6;
    logic signed [79:0] a3;
    logic signed [63:0] v2;
    logic signed [63:0] w1;
    logic signed [80:0] m;
    logic [20:0]        padc;
    logic [63:0]        n0;
    logic [63:0]        num;

    logic signed [63:0] r1_vv;
    logic signed [48:0] r1_vp5;
    logic signed [48:0] r1_vp2;
    logic signed [63:0] r2_a6;
    logic signed [63:0] r2_a3;
    logic signed [48:0] r2_vp5;
    logic signed [48:0] r2_vp2;
    logic signed [63:0] r3_v2;
    logic signed [63:0] r3_w1;
    logic signed [63:0] r4_m;
    logic signed [63:0] r4_v2;
    logic [63:0]        r5_n0;
    logic signed [63:0] r5_den;
    t_hstage            r1_d;
    t_hstage            r2_d;
    t_hstage            r3_d;
    t_hstage            r4_d;
    t_hstage            r5_d;
    t_pstage            r_out;

    always_comb begin
        v1   = $signed({i_data.tfine[31], i_data.tfine}) - PRESS_T_OFS;
        vv   = v1 * v1;
        vp5  = v1 * i_cal.p5;
        vp2  = v1 * i_cal.p2;

        a6   = r1_vv * i_cal.p6;
        a3   = r1_vv * i_cal.p3;

        v2   = r2_a6 + (64'(r2_vp5) <<< 17) + (64'(i_cal.p4) <<< 35);
        w1   = (r2_a3 >>> 8) + (64'(r2_vp2) <<< 12);

        m    = (PRESS_P1_BIAS + r3_w1) * $signed({1'b0, i_cal.p1});

        padc = PRESS_ADC_OFS - {1'b0, r4_d.adc_p};
        n0   = ({43'b0, padc} << 31) - r4_v2;

        num  = r5_n0 * PRESS_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vv      <= vv[63:0];
            r1_vp5     <= vp5;
            r1_vp2     <= vp2;
            r1_d       <= i_data;
            r2_a6      <= a6[63:0];
            r2_a3      <= a3[63:0];
            r2_vp5     <= r1_vp5;
            r2_vp2     <= r1_vp2;
            r2_d       <= r1_d;
            r3_v2      <= v2;
            r3_w1      <= w1;
            r3_d       <= r2_d;
            r4_m       <= m[63:0];
            r4_v2      <= r3_v2;
            r4_d       <= r3_d;
            r5_n0      <= n0;
            r5_den     <= r4_m >>> 33;
            r5_d       <= r4_d;
            r_out.num  <= num;
            r_out.den  <= r5_den;
            r_out.temp <= r5_d.temp;
            r_out.hum  <= r5_d.hum;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r_out;

endmodule

[hw/rtl/esc_div.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage.
module esc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  esc_pkg::t_pstage i_data,
    output logic             o_valid,
    output esc_pkg::t_qstage o_data
);
    import esc_pkg::*;

    localparam int unsigned STEPS = 64;

    logic [STEPS:0] r_dv;
    logic [63:0]    r_rem [0:STEPS];
    logic [63:0]    r_dq  [0:STEPS];
    logic [63:0]    r_ad  [0:STEPS];
    t_div_side      r_sd  [0:STEPS];
    logic [63:0]    an;
    logic [63:0]    ad;
    t_div_side      sd0;
    logic           r_ov;
    t_qstage        r_out;

    always_comb begin
        an        = i_data.num[63] ? (64'd0 - i_data.num) : i_data.num;
        ad        = i_data.den[63] ? (64'd0 - i_data.den) : i_data.den;
        sd0.temp  = i_data.temp;
        sd0.hum   = i_data.hum;
        sd0.inval = (i_data.den == 64'sd0);
        sd0.neg   = i_data.num[63] ^ i_data.den[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_dv <= {r_dv[STEPS-1:0], i_valid};
            r_ov <= r_dv[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= an;
            r_ad[0]  <= ad;
            r_sd[0]  <= sd0;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [64:0] trial;
        logic [64:0] diff;
        logic        take;

        always_comb begin
            trial = {r_rem[g], r_dq[g][63]};
            diff  = trial - {1'b0, r_ad[g]};
            take  = !diff[64];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= take ? diff[63:0] : trial[63:0];
                r_dq[g+1]  <= {r_dq[g][62:0], take};
                r_ad[g+1]  <= r_ad[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.quot  <= r_sd[STEPS].neg ? $signed(64'd0 - r_dq[STEPS]) : $signed(r_dq[STEPS]);
            r_out.temp  <= r_sd[STEPS].temp;
            r_out.hum   <= r_sd[STEPS].hum;
            r_out.inval <= r_sd[STEPS].inval;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

[hw/rtl/env_sensor_raw_compensation.sv]
// Top level: calibration registers, stage chain, pressure tail and output skid.
//
// Usage: write the five calibration registers through i_cfg_we / i_cfg_idx /
// i_cfg_data while the block is idle (index 0 temperature words, 1 and 2
// pressure words, 3 the P9 coefficient, 4 humidity words; other indexes are
// ignored). Send raw triplets on i_in; each request yields exactly one result
// on o_out, in order.
// Throughput: one request per clock cycle while i_in.ready is high. A request
// reaches o_out.valid through the temperature, humidity and pressure multiply
// stages, the 64-step quotient pipeline and the pressure tail stages after it.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls, the output register holds its result and one
// more result parks in a skid register; i_in.ready then drops and the whole
// pipeline freezes with nothing lost or repeated.
module env_sensor_raw_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    esc_in_if.sink      i_in,
    esc_out_if.source   o_out
);
    import esc_pkg::*;

    logic [47:0]        r_cal_temp;
    logic [63:0]        r_cal_plo;
    logic [63:0]        r_cal_phi;
    logic [15:0]        r_cal_p9;
    logic [63:0]        r_cal_hum;
    t_cal               cal;
    logic               en;
    t_in                req;
    logic               t_valid;
    t_tstage            t_data;
    logic               h_valid;
    t_hstage            h_data;
    logic               p_valid;
    t_pstage            p_data;
    logic               d_valid;
    t_qstage            d_data;

    logic signed [63:0] q;
    logic [31:0]        ql;
    logic signed [18:0] qh;
    logic [63:0]        ll;
    logic signed [51:0] lh;
    logic signed [79:0] p8p;
    logic [63:0]        qq;
    logic signed [79:0] m9;
    logic signed [63:0] v1b;
    logic signed [63:0] pf;
    t_out               res;

    logic [3:0]         r_qv;
    logic [63:0]        r1_ll;
    logic [31:0]        r1_lh;
    logic signed [63:0] r1_p8p;
    t_qstage            r1_d;
    logic [63:0]        r2_qq;
    logic signed [63:0] r2_v2b;
    t_qstage            r2_d;
    logic signed [63:0] r3_m9;
    logic signed [63:0] r3_v2b;
    t_qstage            r3_d;
    t_out               r4_res;
    logic               r_out_valid;
    logic               r_skid_valid;
    t_out               r_out;
    t_out               r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp <= '0;
            r_cal_plo  <= '0;
            r_cal_phi  <= '0;
            r_cal_p9   <= '0;
            r_cal_hum  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:     r_cal_temp <= i_cfg_data[47:0];
                CFG_PRESS_LO: r_cal_plo  <= i_cfg_data;
                CFG_PRESS_HI: r_cal_phi  <= i_cfg_data;
                CFG_PRESS_P9: r_cal_p9   <= i_cfg_data[15:0];
                CFG_HUM:      r_cal_hum  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = r_cal_temp[15:0];
        cal.t2 = r_cal_temp[31:16];
        cal.t3 = r_cal_temp[47:32];
        cal.p1 = r_cal_plo[15:0];
        cal.p2 = r_cal_plo[31:16];
        cal.p3 = r_cal_plo[47:32];
        cal.p4 = r_cal_plo[63:48];
        cal.p5 = r_cal_phi[15:0];
        cal.p6 = r_cal_phi[31:16];
        cal.p7 = r_cal_phi[47:32];
        cal.p8 = r_cal_phi[63:48];
        cal.p9 = r_cal_p9;
        cal.h1 = r_cal_hum[7:0];
        cal.h2 = r_cal_hum[23:8];
        cal.h3 = r_cal_hum[31:24];
        cal.h4 = r_cal_hum[43:32];
        cal.h5 = r_cal_hum[55:44];
        cal.h6 = r_cal_hum[63:56];
    end

    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    always_comb begin
        req.raw_pressure    = i_in.raw_pressure;
        req.raw_temperature = i_in.raw_temperature;
        req.raw_humidity    = i_in.raw_humidity;
    end

    esc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_data  (req),
        .i_cal   (cal),
        .o_valid (t_valid),
        .o_data  (t_data)
    );

    esc_hum u_hum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (t_valid),
        .i_data  (t_data),
        .i_cal   (cal),
        .o_valid (h_valid),
        .o_data  (h_data)
    );

    esc_press_pre u_press_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (h_valid),
        .i_data  (h_data),
        .i_cal   (cal),
        .o_valid (p_valid),
        .o_data  (p_data)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_data  (p_data),
        .o_valid (d_valid),
        .o_data  (d_data)
    );

    always_comb begin
        q   = d_data.quot >>> 13;
        ql  = q[31:0];
        qh  = q[50:32];
        ll  = ql * ql;
        lh  = $signed({1'b0, ql}) * qh;
        p8p = d_data.quot * cal.p8;

        qq  = r1_ll + {r1_lh[30:0], 33'b0};

        m9  = $signed(r2_qq) * cal.p9;

        v1b = r3_m9 >>> 25;
        pf  = ((r3_d.quot + v1b + r3_v2b) >>> 8) + (64'(cal.p7) <<< 4);
        res.temperature_centi = r3_d.temp;
        res.pressure_q24_8    = r3_d.inval ? 32'd0 : pf[31:0];
        res.humidity_q22_10   = r3_d.hum;
        res.pressure_invalid  = r3_d.inval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else if (en) begin
            r_qv <= {r_qv[2:0], d_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ll  <= ll;
            r1_lh  <= lh[31:0];
            r1_p8p <= p8p[63:0];
            r1_d   <= d_data;
            r2_qq  <= qq;
            r2_v2b <= r1_p8p >>> 19;
            r2_d   <= r1_d;
            r3_m9  <= m9[63:0];
            r3_v2b <= r2_v2b;
            r3_d   <= r2_d;
            r4_res <= res;
        end
    end

    // advance the output register, park a result in the skid on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_qv[3];
            end
        end else if (en && r_qv[3]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : r4_res;
        end else if (en) begin
            r_skid <= r4_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_centi = r_out.temperature_centi;
    assign o_out.pressure_q24_8    = r_out.pressure_q24_8;
    assign o_out.humidity_q22_10   = r_out.humidity_q22_10;
    assign o_out.pressure_invalid  = r_out.pressure_invalid;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && en && r_qv[3]) |=> r_skid_valid)
        else $error("stalled result not parked in the skid register");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pressure_invalid) |-> (o_out.pressure_q24_8 == 32'd0))
        else $error("invalid pressure result is not zero");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.humidity_q22_10 <= HUM_MAX_Q10))
        else $error("humidity result above full scale");
`endif

endmodule
